/* hdl/skst_pkg.sv */
// shared types and codes for the sorted key store
package skst_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned PayW   = 10;
  localparam int unsigned StatW  = 3;
  localparam int unsigned TotalW = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [StatW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatW-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [StatW-1:0] ST_FULL      = 3'd2;
  localparam logic [StatW-1:0] ST_FOUND     = 3'd3;
  localparam logic [StatW-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [StatW-1:0] ST_DELETED   = 3'd5;
  localparam logic [StatW-1:0] ST_EMPTY     = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic [1:0]             opcode;
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } skst_in_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [PayW-1:0]   found_payload;
    logic [TotalW-1:0] entry_total;
  } skst_out_t;

  // control broadcast to every cell
  typedef struct packed {
    logic compare;
    logic insert;
    logic remove;
  } skst_cmd_t;

endpackage

/* hdl/sorted_key_store.sv */
// top level of the sorted key store: request control and the chain of cells
// a request passes the compare step, then the apply step, which waits while an untaken result holds the output register
// one request at a time: a new request is accepted only in the idle step, after the compare and apply steps of the last
// a new request is taken while the previous result still waits in the output register
// reset: asynchronous active low, clears the entry count and the handshake state
// stored keys and payloads are not cleared; only entries below the count are used
module sorted_key_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  skst_pkg::skst_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output skst_pkg::skst_out_t  out_data_o
);
  import skst_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  skst_in_t        req_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  skst_out_t       out_q, out_d;

  skst_cmd_t       cmd;
  logic            do_compare, do_insert, do_remove;
  logic            apply_go;
  logic            in_fire;

  logic signed [KeyW-1:0] key_w     [CAPACITY];
  logic [PayW-1:0]        pay_w     [CAPACITY];
  logic [PayW-1:0]        hit_pay_w [CAPACITY];
  logic [CAPACITY-1:0]    lt_w, eq_w, occ_w;

  logic            any_eq;
  logic [PayW-1:0] hit_pay;
  logic            is_empty, is_full;
  logic [CntW+TotalW-1:0] count_ext;

  assign in_fire  = in_valid_i && in_ready_o;
  assign apply_go = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  assign cmd = '{compare: do_compare, insert: do_insert, remove: do_remove};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: if (apply_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    do_compare = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_CMP:   do_compare = 1'b1;
      S_APPLY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                   left_lt;
      logic signed [KeyW-1:0] left_key, right_key;
      logic [PayW-1:0]        left_pay, right_pay;

      assign occ_w[gi] = count_q > CntW'(gi);

      if (gi == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_key = '0;
        assign left_pay = '0;
      end else begin : g_mid
        assign left_lt  = lt_w[gi-1];
        assign left_key = key_w[gi-1];
        assign left_pay = pay_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_key = '0;
        assign right_pay = '0;
      end else begin : g_inner
        assign right_key = key_w[gi+1];
        assign right_pay = pay_w[gi+1];
      end

      skst_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .occ_i       (occ_w[gi]),
        .probe_key_i (req_q.key),
        .probe_pay_i (req_q.payload),
        .left_lt_i   (left_lt),
        .left_key_i  (left_key),
        .left_pay_i  (left_pay),
        .right_key_i (right_key),
        .right_pay_i (right_pay),
        .key_o       (key_w[gi]),
        .pay_o       (pay_w[gi]),
        .lt_o        (lt_w[gi]),
        .eq_o        (eq_w[gi]),
        .hit_pay_o   (hit_pay_w[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pay = hit_pay | hit_pay_w[i];
    end
  end

  assign any_eq   = |eq_w;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(CAPACITY));

  // decide the outcome and drive the chain's shift
  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    count_d   = count_q;
    out_d.status        = ST_NOTFOUND;
    out_d.found_payload = '0;
    unique case (req_q.opcode)
      OP_INSERT: begin
        if (any_eq) begin
          out_d.status = ST_DUPLICATE;
        end else if (is_full) begin
          out_d.status = ST_FULL;
        end else begin
          out_d.status = ST_INSERTED;
          do_insert    = apply_go;
          count_d      = count_q + CntW'(1);
        end
      end
      OP_SEARCH: begin
        if (is_empty) begin
          out_d.status = ST_EMPTY;
        end else if (any_eq) begin
          out_d.status        = ST_FOUND;
          out_d.found_payload = hit_pay;
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          out_d.status = ST_EMPTY;
        end else if (any_eq) begin
          out_d.status = ST_DELETED;
          do_remove    = apply_go;
          count_d      = count_q - CntW'(1);
        end
      end
      default: ;
    endcase
    count_ext         = {{TotalW{1'b0}}, count_d};
    out_d.entry_total = count_ext[TotalW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (apply_go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |-> $onehot0(eq_w))
    else $error("more than one cell matches the probe");

  a_result_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_APPLY))
    else $error("result raised outside the apply step");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(apply_go) |-> $stable(count_q))
    else $error("entry count changed without an applied request");
`endif

endmodule

/* hdl/skst_cell.sv */
// one storage cell of the sorted chain: compares against the probe and shifts with neighbors
module skst_cell (
  input  logic                            clk_i,
  input  skst_pkg::skst_cmd_t             cmd_i,
  input  logic                            occ_i,
  input  logic signed [skst_pkg::KeyW-1:0] probe_key_i,
  input  logic [skst_pkg::PayW-1:0]       probe_pay_i,
  input  logic                            left_lt_i,
  input  logic signed [skst_pkg::KeyW-1:0] left_key_i,
  input  logic [skst_pkg::PayW-1:0]       left_pay_i,
  input  logic signed [skst_pkg::KeyW-1:0] right_key_i,
  input  logic [skst_pkg::PayW-1:0]       right_pay_i,
  output logic signed [skst_pkg::KeyW-1:0] key_o,
  output logic [skst_pkg::PayW-1:0]       pay_o,
  output logic                            lt_o,
  output logic                            eq_o,
  output logic [skst_pkg::PayW-1:0]       hit_pay_o
);
  import skst_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0]        pay_q, pay_d;
  logic                   lt_q, eq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      lt_q <= occ_i && (key_q < probe_key_i);
      eq_q <= occ_i && (key_q == probe_key_i);
    end
  end

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (cmd_i.insert && !lt_q) begin
      // first cell at or above the probe takes the new entry, the rest move up
      if (left_lt_i) begin
        key_d = probe_key_i;
        pay_d = probe_pay_i;
      end else begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end
    end else if (cmd_i.remove && !lt_q) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o     = key_q;
  assign pay_o     = pay_q;
  assign lt_o      = lt_q;
  assign eq_o      = eq_q;
  assign hit_pay_o = eq_q ? pay_q : '0;

endmodule
